@@ rtl/core/gct_pkg.sv @@
package gct_pkg;

  // fixed field widths
  localparam int CFG_W      = 6;
  localparam int BYTE_W     = 8;
  localparam int ROW_BITS_W = 32;
  localparam int ROW_NUM_W  = 5;
  localparam int CFG_IDX_W  = 1;

  // output beat: row bits and row number padded to whole bytes
  localparam int M_DATA_W   = ((ROW_BITS_W + ROW_NUM_W + 7) / 8) * 8;

  // default matrix size and register reset values
  localparam int MAX_DIM_DEF  = 32;
  localparam int WIDTH_RESET  = 16;
  localparam int HEIGHT_RESET = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GLYPH_WIDTH  = 1'b0,
    REG_GLYPH_HEIGHT = 1'b1
  } cfg_reg_t;

  // controller states
  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic byte_wr;
    logic row_shift;
    logic emitting;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_byte;
    logic last_row;
  } dp_status_t;

endpackage

@@ rtl/core/gct_datapath.sv @@
module gct_datapath
  import gct_pkg::*;
#(
  parameter int MaxDim = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic [BYTE_W-1:0]     source_byte,
  output logic [ROW_BITS_W-1:0] row_bits,
  output logic [ROW_NUM_W-1:0]  row_number
);

  localparam int DIM_W  = $clog2(MaxDim + 1);
  localparam int ROW_W  = $clog2(MaxDim);
  localparam int GROUPS = (MaxDim + 7) / 8;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int EXT_W  = (CFG_W > DIM_W) ? CFG_W + 1 : DIM_W + 1;

  logic [CFG_W-1:0]  glyph_width;
  logic [CFG_W-1:0]  glyph_height;
  logic [DIM_W-1:0]  width_eff;
  logic [DIM_W-1:0]  height_eff;
  logic [DIM_W:0]    height_round;
  logic [GRP_W:0]    per_col;
  logic [ROW_W-1:0]  col;
  logic [GRP_W-1:0]  group;
  logic [ROW_W-1:0]  row_cnt;
  logic              col_last;
  logic              grp_last;
  logic [MaxDim-1:0] width_mask;
  logic [MaxDim-1:0] matrix [MaxDim];

  // clamp register values to 1..MaxDim
  always_comb begin
    if (glyph_width == '0) begin
      width_eff = DIM_W'(1);
    end else if (EXT_W'(glyph_width) > EXT_W'(MaxDim)) begin
      width_eff = DIM_W'(MaxDim);
    end else begin
      width_eff = DIM_W'(glyph_width);
    end
    if (glyph_height == '0) begin
      height_eff = DIM_W'(1);
    end else if (EXT_W'(glyph_height) > EXT_W'(MaxDim)) begin
      height_eff = DIM_W'(MaxDim);
    end else begin
      height_eff = DIM_W'(glyph_height);
    end
  end

  // bytes per column and end-of-glyph detection
  assign height_round = {1'b0, height_eff} + (DIM_W+1)'(7);
  assign per_col      = (GRP_W+1)'(height_round >> 3);
  assign grp_last     = ({1'b0, group} == per_col - (GRP_W+1)'(1));
  assign col_last     = (DIM_W'(col) == width_eff - DIM_W'(1));

  assign status.last_byte = col_last && grp_last;
  assign status.last_row  = (DIM_W'(row_cnt) == height_eff - DIM_W'(1));

  // config registers and scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width  <= CFG_W'(WIDTH_RESET);
      glyph_height <= CFG_W'(HEIGHT_RESET);
      col          <= '0;
      group        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_GLYPH_WIDTH:  glyph_width  <= cfg_wdata;
        REG_GLYPH_HEIGHT: glyph_height <= cfg_wdata;
      endcase
      col   <= '0;
      group <= '0;
    end else if (cmd.byte_wr) begin
      if (grp_last) begin
        group <= '0;
        if (col_last) begin
          col <= '0;
        end else begin
          col <= col + ROW_W'(1);
        end
      end else begin
        group <= group + GRP_W'(1);
      end
    end
  end

  // output row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
    end else if (cmd.byte_wr) begin
      row_cnt <= '0;
    end else if (cmd.row_shift) begin
      row_cnt <= row_cnt + ROW_W'(1);
    end
  end

  // pixel rows: byte bits land in one column, rows shift up while emitting
  for (genvar r = 0; r < MaxDim; r++) begin : g_row
    always_ff @(posedge clk) begin
      if (cmd.row_shift) begin
        if (r < MaxDim - 1) begin
          matrix[r] <= matrix[(r < MaxDim - 1) ? r + 1 : r];
        end
      end else if (cmd.byte_wr && group == GRP_W'(r / 8) &&
                   DIM_W'(r) < height_eff) begin
        matrix[r][col] <= source_byte[7 - (r % 8)];
      end
    end
  end

  // mask off columns at or beyond the width
  always_comb begin
    for (int c = 0; c < MaxDim; c++) begin
      width_mask[c] = (DIM_W'(c) < width_eff);
    end
  end

  assign row_bits   = ROW_BITS_W'(matrix[0] & width_mask);
  assign row_number = ROW_NUM_W'(row_cnt);

  // scan position stays inside the glyph
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    DIM_W'(col) < width_eff)
    else $error("column index beyond glyph width");

  a_grp_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, group} < per_col)
    else $error("byte group beyond column height");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emitting |-> DIM_W'(row_cnt) < height_eff)
    else $error("emitted row beyond glyph height");

endmodule

@@ rtl/core/gct_ctrl.sv @@
module gct_ctrl
  import gct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (s_tvalid && status.last_byte) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (m_tready && status.last_row) begin
          state_next = ST_LOAD;
        end
      end
    endcase
  end

  // handshakes and datapath commands
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      ST_LOAD: s_tready = 1'b1;
      ST_EMIT: m_tvalid = 1'b1;
    endcase
    cmd.byte_wr   = s_tvalid && s_tready;
    cmd.row_shift = m_tvalid && m_tready;
    cmd.emitting  = m_tvalid;
  end

  // glyph completes into emit, final row returns to load
  a_enter_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.byte_wr && status.last_byte) |=> state == ST_EMIT)
    else $error("last byte did not start row output");

  a_leave_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.row_shift && status.last_row) |=> state == ST_LOAD)
    else $error("final row did not return to load");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !m_tready) |=> state == ST_EMIT)
    else $error("row output dropped while stalled");

endmodule

@@ rtl/core/glyph_column_to_row_transpose_unit.sv @@
// Glyph column-to-row transpose.
// Source bytes arrive on the s_ stream in column-scan order, ceil(height/8)
// bytes per column, bit 7 being the topmost row of the byte's group. Rows
// at or beyond the glyph height are dropped. One byte is taken per cycle
// while loading; a glyph loads as width * ceil(height/8) bytes.
// The cycle after the last byte, the m_ stream starts emitting one row per
// beat, top row first: tdata bit c is column c (zero at or beyond the width),
// tdata bits 36:32 carry the row number and tlast marks the final row. Rows
// leave one per cycle when m_tready is held high, and the row shift register
// sets the output pace, shifting each following row up to the top.
// s_tready is low while rows are emitted; a stall on m_tready holds the
// current row and row number stable until taken. After the last row the
// block is ready for the next glyph's first byte on the following cycle.
// Width and height are written on the cfg port (index 0 width, 1 height),
// values of zero act as one and values above MaxDim act as MaxDim. Any
// config write restarts the glyph scan. Reset sets both sizes to 16 and
// puts the block in the loading state at the first byte of a glyph.
module glyph_column_to_row_transpose_unit
  import gct_pkg::*;
#(
  parameter int MaxDim = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] source_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // [31:0] row_bits, [36:32] row_number, [39:37] zero
  output logic                  m_tlast    // last_row
);

  dp_cmd_t               cmd;
  dp_status_t            status;
  logic [ROW_BITS_W-1:0] row_bits;
  logic [ROW_NUM_W-1:0]  row_number;

  // sequencing
  gct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // pixel matrix and counters
  gct_datapath #(
    .MaxDim (MaxDim)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .status      (status),
    .source_byte (s_tdata),
    .row_bits    (row_bits),
    .row_number  (row_number)
  );

  // pack the output beat
  assign m_tdata = {{(M_DATA_W - ROW_BITS_W - ROW_NUM_W){1'b0}}, row_number, row_bits};
  assign m_tlast = status.last_row;

endmodule
